// File: hdl/assert_macros.svh
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication under reset.
`define PCPRI_ASSERT_IMPLY(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication under reset.
`define PCPRI_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: hdl/pcpri_pkg.sv
// Shared types and codes of the paced request issuer.
package pcpri_pkg;

   // Request kinds.
   localparam logic [1:0] KIND_GWRITE = 2'd0;
   localparam logic [1:0] KIND_MAC    = 2'd1;
   localparam logic [1:0] KIND_READ   = 2'd2;

   // Configuration register indexes.
   localparam logic [2:0] CSR_MAC_INTERVAL = 3'd0;
   localparam logic [2:0] CSR_IO_INTERVAL  = 3'd1;
   localparam logic [2:0] CSR_CLOCK_PERIOD = 3'd2;
   localparam logic [2:0] CSR_READ_LATENCY = 3'd3;
   localparam logic [2:0] CSR_WAVE_0       = 3'd4;
   localparam logic [2:0] CSR_WAVE_1       = 3'd5;
   localparam logic [2:0] CSR_WAVE_2       = 3'd6;

   localparam int DIV_STEPS = 25;
   localparam int MUL_STEPS = 16;

   // One buffered request.
   typedef struct packed {
      logic [1:0]  kind;
      logic [3:0]  chan;
      logic [15:0] tag;
   } entry_type;

   // Status of an iterative arithmetic unit.
   typedef struct packed {
      logic busy;
      logic done;
   } unit_status_type;

endpackage

// File: hdl/pcpri_mul.sv
// Shift-and-add multiplier: 48-bit cycle count by 16-bit clock period.
module pcpri_mul (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      start,
   input  logic [47:0]               mcand,
   input  logic [15:0]               mplier,
   output pcpri_pkg::unit_status_type status,
   output logic [63:0]               product
);

   logic [63:0] mcand_ff;
   logic [15:0] mplier_ff;
   logic [63:0] acc_ff;
   logic [4:0]  cnt_ff;
   logic        busy_ff;
   logic        done_ff;

   // One multiplier bit per cycle.
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff   <= 1'b1;
            cnt_ff    <= '0;
            mcand_ff  <= {16'd0, mcand};
            mplier_ff <= mplier;
            acc_ff    <= '0;
         end else if (busy_ff) begin
            if (mplier_ff[0]) begin
               acc_ff <= acc_ff + mcand_ff;
            end
            mcand_ff  <= {mcand_ff[62:0], 1'b0};
            mplier_ff <= {1'b0, mplier_ff[15:1]};
            cnt_ff    <= cnt_ff + 5'd1;
            if (cnt_ff == 5'(pcpri_pkg::MUL_STEPS - 1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   assign product     = acc_ff;
   assign status.busy = busy_ff;
   assign status.done = done_ff;

endmodule

// File: hdl/pcpri_div.sv
// Restoring divider for the ceiling of interval over clock period.
module pcpri_div (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      start,
   input  logic [24:0]               dividend,
   input  logic [15:0]               divisor,
   output pcpri_pkg::unit_status_type status,
   output logic [24:0]               quotient
);

   logic [24:0] dvd_ff;
   logic [15:0] dvs_ff;
   logic [15:0] rem_ff;
   logic [4:0]  cnt_ff;
   logic        busy_ff;
   logic        done_ff;
   logic [16:0] rem_sh;
   logic        qbit;
   logic [16:0] rem_sub;

   // Trial subtraction for the next quotient bit.
   always_comb begin
      rem_sh  = {rem_ff, dvd_ff[24]};
      qbit    = rem_sh >= {1'b0, dvs_ff};
      rem_sub = rem_sh - {1'b0, dvs_ff};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= '0;
            dvd_ff  <= dividend;
            dvs_ff  <= divisor;
            rem_ff  <= '0;
         end else if (busy_ff) begin
            rem_ff <= qbit ? rem_sub[15:0] : rem_sh[15:0];
            dvd_ff <= {dvd_ff[23:0], qbit};
            cnt_ff <= cnt_ff + 5'd1;
            if (cnt_ff == 5'(pcpri_pkg::DIV_STEPS - 1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   assign quotient    = dvd_ff;
   assign status.busy = busy_ff;
   assign status.done = done_ff;

endmodule

// File: hdl/per_channel_paced_request_issuer.sv
// Top level of the per-channel paced request issuer.
//
//   channel | direction | handshake          | contents
//   req     | in        | req_valid/req_stall | mode, kind, channel, tag
//   rsp     | out       | rsp_valid/rsp_stall | accept/issue result words
//   csr     | in        | csr_we              | register index and data
//
// An enqueue word's result is loaded into the output register.
// A tick runs the multiply, the MAC and IO divides, then the buffer scan, which
// keeps or issues each request, then a finish step that closes the scan, then
// emits one result per cycle while the output register is not stalled.
// The buffer scan through the request memory sets the tick length.
// Reset is synchronous and clears all control state; memory contents stay undefined.
// A stalled result holds; no new word is taken until the result register is free.
module per_channel_paced_request_issuer #(
   parameter int BUFFER_DEPTH   = 256,
   parameter int NUM_CHANNELS   = 2,
   parameter int NUM_MILESTONES = 3
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic        req_mode,
   input  logic [1:0]  req_kind,
   input  logic [3:0]  req_channel,
   input  logic [15:0] req_tag,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic        rsp_accepted,
   output logic        rsp_issued,
   output logic [15:0] rsp_out_tag,
   output logic [3:0]  rsp_out_channel,
   output logic [1:0]  rsp_out_kind,
   output logic [47:0] rsp_completion_cycle,
   output logic [2:0]  rsp_milestone_hits,
   output logic        rsp_pending,
   output logic        rsp_last,
   input  logic        csr_we,
   input  logic [2:0]  csr_index,
   input  logic [23:0] csr_wdata
);

   localparam int AW = (BUFFER_DEPTH > 1) ? $clog2(BUFFER_DEPTH) : 1;
   localparam int NW = $clog2(BUFFER_DEPTH + 1);
   localparam int CW = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
   localparam int RW = $clog2(NUM_CHANNELS + 1);

   typedef enum logic [3:0] {
      ST_IDLE, ST_MUL, ST_DIV_MAC, ST_DIV_IO, ST_READ, ST_EVAL,
      ST_UPDATE, ST_MILESTONE, ST_FINISH, ST_EMIT
   } state_type;

   // Configuration registers.
   logic [23:0] mac_iv_ff;
   logic [23:0] io_iv_ff;
   logic [15:0] period_ff;
   logic [7:0]  rd_lat_ff;
   logic [15:0] wave_ff [3];

   // Issuer state.
   state_type   state_ff;
   logic [NW-1:0] count_ff;
   logic [NW-1:0] rd_ff;
   logic [NW-1:0] wr_ff;
   logic [47:0] cycle_ff;
   logic [63:0] nit_ff [NUM_CHANNELS];
   logic [31:0] cnt_ff [NUM_CHANNELS];
   logic [47:0] latest_ff;
   logic [2:0]  reached_ff;
   logic [NUM_CHANNELS-1:0] took_ff;
   logic [63:0] now_ps_ff;
   logic [24:0] q_mac_ff;
   logic [63:0] diff_ff;
   pcpri_pkg::entry_type entry_ff;

   // Results of one tick, waiting for the final pending flag.
   logic [15:0] res_tag_ff  [NUM_CHANNELS];
   logic [3:0]  res_chan_ff [NUM_CHANNELS];
   logic [1:0]  res_kind_ff [NUM_CHANNELS];
   logic [47:0] res_done_ff [NUM_CHANNELS];
   logic [2:0]  res_hits_ff [NUM_CHANNELS];
   logic [RW-1:0] res_n_ff;
   logic [RW-1:0] emit_idx_ff;

   // Output register.
   logic        rsp_valid_ff;
   logic        rsp_accepted_ff;
   logic        rsp_issued_ff;
   logic [15:0] rsp_tag_ff;
   logic [3:0]  rsp_chan_ff;
   logic [1:0]  rsp_kind_ff;
   logic [47:0] rsp_done_ff;
   logic [2:0]  rsp_hits_ff;
   logic        rsp_pending_ff;
   logic        rsp_last_ff;

   // Request memory.
   pcpri_pkg::entry_type mem [BUFFER_DEPTH];
   pcpri_pkg::entry_type mem_rdata_ff;
   logic                 mem_we;
   logic [AW-1:0]        mem_waddr;
   pcpri_pkg::entry_type mem_wdata;

   // Arithmetic units.
   pcpri_pkg::unit_status_type mul_status;
   pcpri_pkg::unit_status_type div_status;
   logic        mul_start;
   logic        div_start;
   logic [63:0] mul_product;
   logic [24:0] div_quotient;
   logic [24:0] div_dividend;
   logic [15:0] period_eff;

   // Decoded control.
   logic        req_accept;
   logic        out_free;
   logic        enq_ok;
   logic [CW-1:0] e_ch;
   logic        e_ch_ok;
   logic        e_ready;
   logic [23:0] e_iv;
   logic [47:0] e_done;
   logic [63:0] nit_in;
   logic [31:0] cnt_in;
   logic [2:0]  hits_in;
   logic [2:0]  reached_in;
   logic        all_reached;
   logic        pend_now;
   logic [CW-1:0] emit_sel;

   assign period_eff = (period_ff == 16'd0) ? 16'd1 : period_ff;
   assign out_free   = !rsp_valid_ff || !rsp_stall;
   assign req_stall  = !(state_ff == ST_IDLE && !rsp_valid_ff);
   assign req_accept = req_valid && !req_stall;
   assign enq_ok     = req_kind <= pcpri_pkg::KIND_READ
                       && {1'b0, req_channel} < 5'(NUM_CHANNELS)
                       && count_ff < NW'(BUFFER_DEPTH);

   // Unit starts and divider operand selection.
   assign mul_start    = req_accept && req_mode;
   assign div_start    = (state_ff == ST_MUL && mul_status.done)
                         || (state_ff == ST_DIV_MAC && div_status.done);
   assign div_dividend = (state_ff == ST_MUL)
                         ? 25'(mac_iv_ff) + 25'(period_eff) - 25'd1
                         : 25'(io_iv_ff) + 25'(period_eff) - 25'd1;

   pcpri_mul u_mul (
      .clock   (clock),
      .reset   (reset),
      .start   (mul_start),
      .mcand   (cycle_ff),
      .mplier  (period_eff),
      .status  (mul_status),
      .product (mul_product)
   );

   pcpri_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dividend),
      .divisor  (period_eff),
      .status   (div_status),
      .quotient (div_quotient)
   );

   // Per-entry decisions of the scan.
   always_comb begin
      e_ch    = entry_ff.chan[CW-1:0];
      e_ch_ok = {1'b0, mem_rdata_ff.chan} < 5'(NUM_CHANNELS);
      e_ready = e_ch_ok && !took_ff[mem_rdata_ff.chan[CW-1:0]]
                && now_ps_ff >= nit_ff[mem_rdata_ff.chan[CW-1:0]];
      e_iv    = (entry_ff.kind == pcpri_pkg::KIND_MAC) ? mac_iv_ff : io_iv_ff;
      if (entry_ff.kind == pcpri_pkg::KIND_READ) begin
         e_done = cycle_ff + 48'(rd_lat_ff);
      end else if (entry_ff.kind == pcpri_pkg::KIND_MAC) begin
         e_done = cycle_ff + 48'(q_mac_ff);
      end else begin
         e_done = cycle_ff + 48'(div_quotient);
      end
      if (cnt_ff[e_ch] == 32'd0 || diff_ff >= 64'(e_iv)) begin
         nit_in = now_ps_ff + 64'(e_iv);
      end else begin
         nit_in = nit_ff[e_ch] + 64'(e_iv);
      end
      cnt_in = (cnt_ff[e_ch] == 32'hFFFF_FFFF) ? cnt_ff[e_ch] : cnt_ff[e_ch] + 32'd1;
   end

   // Milestones: reached when every channel has issued at least the wave count.
   always_comb begin
      hits_in    = 3'd0;
      reached_in = reached_ff;
      for (int i = 0; i < NUM_MILESTONES; i++) begin
         all_reached = 1'b1;
         for (int c = 0; c < NUM_CHANNELS; c++) begin
            if (cnt_ff[c] < 32'(wave_ff[i])) begin
               all_reached = 1'b0;
            end
         end
         if (!reached_ff[i] && all_reached) begin
            reached_in[i] = 1'b1;
            hits_in[i]    = 1'b1;
         end
      end
   end

   assign pend_now = count_ff != '0 || cycle_ff < latest_ff;
   assign emit_sel = emit_idx_ff[CW-1:0];

   // Memory write port: enqueue at the tail, or compaction during the scan.
   always_comb begin
      mem_we    = 1'b0;
      mem_waddr = count_ff[AW-1:0];
      mem_wdata = '{kind: req_kind, chan: req_channel, tag: req_tag};
      if (req_accept && !req_mode && enq_ok) begin
         mem_we = 1'b1;
      end else if (state_ff == ST_EVAL && !e_ready) begin
         mem_we    = 1'b1;
         mem_waddr = wr_ff[AW-1:0];
         mem_wdata = mem_rdata_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_waddr] <= mem_wdata;
      end
      mem_rdata_ff <= mem[rd_ff[AW-1:0]];
   end

   // Sequencer, issuer state and output register.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         mac_iv_ff    <= 24'd24576;
         io_iv_ff     <= 24'd1024;
         period_ff    <= 16'd1000;
         rd_lat_ff    <= 8'd20;
         wave_ff[0]   <= 16'd1;
         wave_ff[1]   <= 16'd2;
         wave_ff[2]   <= 16'd4;
         count_ff     <= '0;
         rd_ff        <= '0;
         wr_ff        <= '0;
         cycle_ff     <= '0;
         latest_ff    <= '0;
         reached_ff   <= '0;
         took_ff      <= '0;
         res_n_ff     <= '0;
         emit_idx_ff  <= '0;
         rsp_valid_ff <= 1'b0;
         for (int c = 0; c < NUM_CHANNELS; c++) begin
            nit_ff[c] <= '0;
            cnt_ff[c] <= '0;
         end
      end else begin
         // Configuration writes.
         if (csr_we) begin
            unique case (csr_index)
               pcpri_pkg::CSR_MAC_INTERVAL: mac_iv_ff  <= csr_wdata;
               pcpri_pkg::CSR_IO_INTERVAL:  io_iv_ff   <= csr_wdata;
               pcpri_pkg::CSR_CLOCK_PERIOD: period_ff  <= csr_wdata[15:0];
               pcpri_pkg::CSR_READ_LATENCY: rd_lat_ff  <= csr_wdata[7:0];
               pcpri_pkg::CSR_WAVE_0:       wave_ff[0] <= csr_wdata[15:0];
               pcpri_pkg::CSR_WAVE_1:       wave_ff[1] <= csr_wdata[15:0];
               pcpri_pkg::CSR_WAVE_2:       wave_ff[2] <= csr_wdata[15:0];
               default: ;
            endcase
         end

         // A taken word frees the output register; while emitting, the
         // emit step reloads it instead.
         if (rsp_valid_ff && !rsp_stall && state_ff != ST_EMIT) begin
            rsp_valid_ff <= 1'b0;
         end

         unique case (state_ff)
            ST_IDLE: begin
               if (req_accept && !req_mode) begin
                  rsp_valid_ff    <= 1'b1;
                  rsp_accepted_ff <= enq_ok;
                  rsp_issued_ff   <= 1'b0;
                  rsp_tag_ff      <= '0;
                  rsp_chan_ff     <= '0;
                  rsp_kind_ff     <= '0;
                  rsp_done_ff     <= '0;
                  rsp_hits_ff     <= '0;
                  rsp_pending_ff  <= enq_ok || pend_now;
                  rsp_last_ff     <= 1'b1;
                  if (enq_ok) begin
                     count_ff <= count_ff + NW'(1);
                  end
               end else if (req_accept) begin
                  state_ff <= ST_MUL;
               end
            end
            ST_MUL: begin
               if (mul_status.done) begin
                  now_ps_ff <= mul_product;
                  state_ff  <= ST_DIV_MAC;
               end
            end
            ST_DIV_MAC: begin
               if (div_status.done) begin
                  q_mac_ff <= div_quotient;
                  state_ff <= ST_DIV_IO;
               end
            end
            ST_DIV_IO: begin
               if (div_status.done) begin
                  rd_ff    <= '0;
                  wr_ff    <= '0;
                  took_ff  <= '0;
                  res_n_ff <= '0;
                  state_ff <= ST_READ;
               end
            end
            ST_READ: begin
               state_ff <= (rd_ff == count_ff) ? ST_FINISH : ST_EVAL;
            end
            ST_EVAL: begin
               entry_ff <= mem_rdata_ff;
               diff_ff  <= now_ps_ff - nit_ff[mem_rdata_ff.chan[CW-1:0]];
               if (e_ready) begin
                  state_ff <= ST_UPDATE;
               end else begin
                  wr_ff    <= wr_ff + NW'(1);
                  rd_ff    <= rd_ff + NW'(1);
                  state_ff <= ST_READ;
               end
            end
            ST_UPDATE: begin
               nit_ff[e_ch]  <= nit_in;
               cnt_ff[e_ch]  <= cnt_in;
               took_ff[e_ch] <= 1'b1;
               if (e_done > latest_ff) begin
                  latest_ff <= e_done;
               end
               res_tag_ff[res_n_ff[CW-1:0]]  <= entry_ff.tag;
               res_chan_ff[res_n_ff[CW-1:0]] <= entry_ff.chan;
               res_kind_ff[res_n_ff[CW-1:0]] <= entry_ff.kind;
               res_done_ff[res_n_ff[CW-1:0]] <= e_done;
               rd_ff    <= rd_ff + NW'(1);
               state_ff <= ST_MILESTONE;
            end
            ST_MILESTONE: begin
               reached_ff                    <= reached_in;
               res_hits_ff[res_n_ff[CW-1:0]] <= hits_in;
               res_n_ff                      <= res_n_ff + RW'(1);
               state_ff                      <= ST_READ;
            end
            ST_FINISH: begin
               count_ff    <= wr_ff;
               cycle_ff    <= cycle_ff + 48'd1;
               emit_idx_ff <= '0;
               state_ff    <= ST_EMIT;
            end
            ST_EMIT: begin
               if (out_free) begin
                  rsp_valid_ff    <= 1'b1;
                  rsp_accepted_ff <= 1'b0;
                  rsp_pending_ff  <= pend_now;
                  if (res_n_ff == '0) begin
                     rsp_issued_ff <= 1'b0;
                     rsp_tag_ff    <= '0;
                     rsp_chan_ff   <= '0;
                     rsp_kind_ff   <= '0;
                     rsp_done_ff   <= '0;
                     rsp_hits_ff   <= '0;
                     rsp_last_ff   <= 1'b1;
                     state_ff      <= ST_IDLE;
                  end else begin
                     rsp_issued_ff <= 1'b1;
                     rsp_tag_ff    <= res_tag_ff[emit_sel];
                     rsp_chan_ff   <= res_chan_ff[emit_sel];
                     rsp_kind_ff   <= res_kind_ff[emit_sel];
                     rsp_done_ff   <= res_done_ff[emit_sel];
                     rsp_hits_ff   <= res_hits_ff[emit_sel];
                     rsp_last_ff   <= emit_idx_ff == res_n_ff - RW'(1);
                     emit_idx_ff   <= emit_idx_ff + RW'(1);
                     if (emit_idx_ff == res_n_ff - RW'(1)) begin
                        state_ff <= ST_IDLE;
                     end
                  end
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_accepted         = rsp_accepted_ff;
   assign rsp_issued           = rsp_issued_ff;
   assign rsp_out_tag          = rsp_tag_ff;
   assign rsp_out_channel      = rsp_chan_ff;
   assign rsp_out_kind         = rsp_kind_ff;
   assign rsp_completion_cycle = rsp_done_ff;
   assign rsp_milestone_hits   = rsp_hits_ff;
   assign rsp_pending          = rsp_pending_ff;
   assign rsp_last             = rsp_last_ff;

endmodule

// File: hdl/pcpri_checker.sv
// Port-level checker for the paced request issuer, with its bind.
`include "assert_macros.svh"

module pcpri_checker #(
   parameter int NUM_CHANNELS = 2
) (
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic        rsp_accepted,
   input logic        rsp_issued,
   input logic [15:0] rsp_out_tag,
   input logic [3:0]  rsp_out_channel,
   input logic [1:0]  rsp_out_kind,
   input logic [2:0]  rsp_milestone_hits,
   input logic        rsp_last
);

   // A stalled result word stays and holds its tag.
   `PCPRI_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_out_tag), "stalled result word changed")

   // An enqueue acceptance is a single, final word and never an issue.
   `PCPRI_ASSERT_IMPLY(a_accept_alone, clock, reset, rsp_valid && rsp_accepted, !rsp_issued && rsp_last, "accept word marked as issue or not last")

   // An issued word carries a known kind and a channel in range.
   `PCPRI_ASSERT_IMPLY(a_issue_fields, clock, reset, rsp_valid && rsp_issued, rsp_out_kind != 2'd3 && {1'b0, rsp_out_channel} < 5'(NUM_CHANNELS), "issued word has bad kind or channel")

   // A word with nothing issued carries no milestones and ends its item.
   `PCPRI_ASSERT_IMPLY(a_idle_tick, clock, reset, rsp_valid && !rsp_issued, rsp_milestone_hits == 3'd0 && rsp_last, "empty word has milestones or is not last")

endmodule

bind per_channel_paced_request_issuer pcpri_checker #(
   .NUM_CHANNELS (NUM_CHANNELS)
) u_pcpri_checker (
   .clock              (clock),
   .reset              (reset),
   .rsp_valid          (rsp_valid),
   .rsp_stall          (rsp_stall),
   .rsp_accepted       (rsp_accepted),
   .rsp_issued         (rsp_issued),
   .rsp_out_tag        (rsp_out_tag),
   .rsp_out_channel    (rsp_out_channel),
   .rsp_out_kind       (rsp_out_kind),
   .rsp_milestone_hits (rsp_milestone_hits),
   .rsp_last           (rsp_last)
);
